>>> design/relay_power_sequencer_core_assert.svh
// Assertion macros shared by the relay power sequencer RTL.
`ifndef RELAY_POWER_SEQUENCER_CORE_ASSERT_SVH
`define RELAY_POWER_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked on clk, off while reset is asserted.
`define RPS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while reset is asserted.
`define RPS_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/rps_pkg.sv
// Types, constants and register codes of the relay power sequencer.
package rps_pkg;

	localparam int CHANNELS  = 8;
	localparam int END_COUNT = 80;
	localparam int NUM_CH    = (CHANNELS < 8) ? CHANNELS : 8;
	localparam int CNT_W     = 7;
	localparam int TICK_W    = 12;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 64;

	typedef enum logic [1:0] {
		ST_RUN        = 2'd0,
		ST_OPEN_DONE  = 2'd1,
		ST_CLOSE_DONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_OPEN_DELAYS    = 2'd0,
		REG_CLOSE_DELAYS   = 2'd1,
		REG_CHANNEL_ENABLE = 2'd2,
		REG_LINK_MODE      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic key_down;
		logic key_changed;
	} in_item_t;

	typedef struct packed {
		logic [7:0] relays;
		logic [1:0] sequence_status;
		logic       last_channel_on;
	} out_item_t;

endpackage

>>> design/relay_power_sequencer_core.sv
// Relay power sequencer: tick handshake, APB registers and sequencing logic.
//
// Takes one 100 ms tick item per clock cycle while the output is not stalled, and
// returns one result item per tick: the tick is held in an input register, the
// eight channel delay compares and the count update run in one combinational pass,
// and the result lands in an output register. A stalled output holds its item while
// the input register still accepts one more. Registers sit on a 64-bit APB port at
// byte addresses 0x00 (open delays), 0x08 (close delays), 0x10 (channel enable)
// and 0x18 (link mode); write them only while no tick is in flight.
module relay_power_sequencer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rps_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rps_pkg::out_item_t            out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rps_pkg::ADDR_W-1:0]    paddr,
	input  logic [rps_pkg::DATA_W-1:0]    pwdata,
	output logic [rps_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

`include "relay_power_sequencer_core_assert.svh"

	// configuration
	logic [63:0] open_delays_q;
	logic [63:0] close_delays_q;
	logic [7:0]  chan_en_q;
	logic        link_q;
	rps_pkg::reg_idx_t reg_sel;

	// sequencing state
	logic [rps_pkg::CNT_W-1:0] open_cnt_q, close_cnt_q;
	rps_pkg::status_t          status_q;
	logic [7:0]                relay_q;
	logic                      top_flag_q;

	// pipeline
	logic               valid_s1;
	rps_pkg::in_item_t  item_s1;
	logic               out_valid_q;
	rps_pkg::out_item_t out_q;
	logic               advance;

	// next-state values
	logic [rps_pkg::CNT_W-1:0] open_cnt_d, close_cnt_d;
	rps_pkg::status_t          status_d;
	logic [7:0]                relay_d;
	logic                      top_flag_d;

	assign reg_sel = rps_pkg::reg_idx_t'(paddr[4:3]);
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_sel)
			rps_pkg::REG_OPEN_DELAYS:    prdata = open_delays_q;
			rps_pkg::REG_CLOSE_DELAYS:   prdata = close_delays_q;
			rps_pkg::REG_CHANNEL_ENABLE: prdata = {56'd0, chan_en_q};
			rps_pkg::REG_LINK_MODE:      prdata = {63'd0, link_q};
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_delays_q  <= '0;
			close_delays_q <= '0;
			chan_en_q      <= 8'hFF;
			link_q         <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				rps_pkg::REG_OPEN_DELAYS:    open_delays_q  <= pwdata;
				rps_pkg::REG_CLOSE_DELAYS:   close_delays_q <= pwdata;
				rps_pkg::REG_CHANNEL_ENABLE: chan_en_q      <= pwdata[7:0];
				rps_pkg::REG_LINK_MODE:      link_q         <= pwdata[0];
				default: ;
			endcase
		end
	end

	// handshake: the output register parts the two sides
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// one tick: restart, count, compare every channel, set done status
	always_comb begin
		logic                      opening;
		logic                      restart;
		logic                      active;
		logic [rps_pkg::CNT_W-1:0] cnt_base;
		logic [rps_pkg::CNT_W-1:0] cnt;
		logic [rps_pkg::CNT_W-1:0] mirror;
		logic [7:0]                secs;
		logic [rps_pkg::TICK_W-1:0] tick;
		logic                      fire;
		logic                      found;
		logic                      top_on;
		rps_pkg::status_t          st_base;
		rps_pkg::status_t          st_done;

		opening  = item_s1.key_down;
		restart  = !link_q && item_s1.key_changed;
		st_done  = opening ? rps_pkg::ST_OPEN_DONE : rps_pkg::ST_CLOSE_DONE;
		st_base  = restart ? rps_pkg::ST_RUN : status_q;
		cnt_base = restart ? '0 : (opening ? open_cnt_q : close_cnt_q);
		active   = (st_base != st_done);
		cnt      = cnt_base + rps_pkg::CNT_W'(1);
		mirror   = rps_pkg::CNT_W'(rps_pkg::END_COUNT) - cnt;
		found    = 1'b0;
		top_on   = 1'b0;
		secs     = '0;
		tick     = '0;
		fire     = 1'b0;

		open_cnt_d  = open_cnt_q;
		close_cnt_d = close_cnt_q;
		status_d    = status_q;
		relay_d     = relay_q;
		top_flag_d  = top_flag_q;

		if (active) begin
			for (int k = 0; k < rps_pkg::NUM_CH; k++) begin
				if (link_q) begin
					secs = opening ? 8'(k + 1) : 8'(rps_pkg::CHANNELS - k);
				end else begin
					secs = opening ? open_delays_q[8*k +: 8] : close_delays_q[8*k +: 8];
				end
				tick = {4'd0, secs} * rps_pkg::TICK_W'(10);
				fire = (secs != 8'd0) && (tick <= rps_pkg::TICK_W'(rps_pkg::END_COUNT))
					&& (tick == {5'd0, cnt}) && chan_en_q[k];
				if (fire) begin
					relay_d[k] = opening;
					if (!opening) begin
						top_flag_d = 1'b0;
					end
				end
			end
			// highest enabled channel wins
			for (int k = 0; k < rps_pkg::NUM_CH; k++) begin
				if (chan_en_q[k]) begin
					found  = 1'b1;
					top_on = relay_d[k];
				end
			end
			if (found && top_on) begin
				top_flag_d = 1'b1;
			end
			status_d = (cnt == rps_pkg::CNT_W'(rps_pkg::END_COUNT)) ? st_done : rps_pkg::ST_RUN;
			if (opening) begin
				open_cnt_d  = cnt;
				close_cnt_d = link_q ? mirror : '0;
			end else begin
				close_cnt_d = cnt;
				open_cnt_d  = link_q ? mirror : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_cnt_q  <= '0;
			close_cnt_q <= '0;
			status_q    <= rps_pkg::ST_RUN;
			relay_q     <= '0;
			top_flag_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				open_cnt_q  <= open_cnt_d;
				close_cnt_q <= close_cnt_d;
				status_q    <= status_d;
				relay_q     <= relay_d;
				top_flag_q  <= top_flag_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.relays          <= relay_d;
			out_q.sequence_status <= status_d;
			out_q.last_channel_on <= top_flag_d;
		end
	end

	`RPS_ASSERT_IMP(a_open_done_at_end, status_q == rps_pkg::ST_OPEN_DONE,
		open_cnt_q == rps_pkg::CNT_W'(rps_pkg::END_COUNT), "open done without end count")
	`RPS_ASSERT_IMP(a_close_done_at_end, status_q == rps_pkg::ST_CLOSE_DONE,
		close_cnt_q == rps_pkg::CNT_W'(rps_pkg::END_COUNT), "close done without end count")
	`RPS_ASSERT_NXT(a_relays_hold, !advance, $stable(relay_q), "relays moved without a tick")

endmodule

>>> tb/tb_relay_power_sequencer_core.sv
// Self-checking testbench for the relay power sequencer: directed and random ticks.
module tb_relay_power_sequencer_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 4;
	localparam int SETTLE_TICKS = 6;
	localparam int LIMIT_NS     = 2_000_000;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	rps_pkg::in_item_t            in_data;
	logic                         out_valid;
	logic                         out_ready;
	rps_pkg::out_item_t           out_data;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [rps_pkg::ADDR_W-1:0]   paddr;
	logic [rps_pkg::DATA_W-1:0]   pwdata;
	logic [rps_pkg::DATA_W-1:0]   prdata;
	logic                         pready;

	// shadow copy of the registers
	logic [63:0] open_delay_bytes;
	logic [63:0] close_delay_bytes;
	logic [7:0]  enabled_mask;
	logic        link_on;

	// predicted sequencer state
	logic [6:0]        open_ticks;
	logic [6:0]        close_ticks;
	rps_pkg::status_t  done_state;
	logic [7:0]        relay_bits;
	logic              top_on;

	rps_pkg::out_item_t relay_results_due[$];
	int                 mismatch_count;
	int                 send_idle_pct;
	int                 recv_idle_pct;

	relay_power_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Tick count at which a channel switches in the given direction; 0 means never.
	function automatic int fire_count(int ch, logic opening);
		int secs;
		if (link_on)
			secs = opening ? ch + 1 : rps_pkg::CHANNELS - ch;
		else
			secs = opening ? int'(open_delay_bytes[8*ch +: 8])
				: int'(close_delay_bytes[8*ch +: 8]);
		if (secs == 0 || secs * 10 > rps_pkg::END_COUNT)
			return 0;
		return secs * 10;
	endfunction

	function automatic void apply_count(logic [6:0] count, logic opening);
		int   t;
		logic found;
		found = 1'b0;
		for (int ch = 0; ch < rps_pkg::NUM_CH; ch++) begin
			t = fire_count(ch, opening);
			if (t != 0 && t == int'(count) && enabled_mask[ch]) begin
				if (opening) begin
					relay_bits[ch] = 1'b1;
				end else begin
					relay_bits[ch] = 1'b0;
					top_on = 1'b0;
				end
			end
		end
		// only the highest enabled channel drives the flag
		for (int ch = rps_pkg::NUM_CH - 1; ch >= 0; ch--) begin
			if (!found && enabled_mask[ch]) begin
				found = 1'b1;
				if (relay_bits[ch])
					top_on = 1'b1;
			end
		end
		if (int'(count) == rps_pkg::END_COUNT)
			done_state = opening ? rps_pkg::ST_OPEN_DONE : rps_pkg::ST_CLOSE_DONE;
		else
			done_state = rps_pkg::ST_RUN;
	endfunction

	function automatic rps_pkg::out_item_t next_relay_result(rps_pkg::in_item_t tick);
		rps_pkg::out_item_t res;
		if (tick.key_down) begin
			if (!link_on && tick.key_changed) begin
				open_ticks = '0;
				done_state = rps_pkg::ST_RUN;
			end
			if (done_state != rps_pkg::ST_OPEN_DONE) begin
				open_ticks = open_ticks + 7'd1;
				apply_count(open_ticks, 1'b1);
				close_ticks = link_on ? 7'(rps_pkg::END_COUNT - int'(open_ticks)) : 7'd0;
			end
		end else begin
			if (!link_on && tick.key_changed) begin
				close_ticks = '0;
				done_state = rps_pkg::ST_RUN;
			end
			if (done_state != rps_pkg::ST_CLOSE_DONE) begin
				close_ticks = close_ticks + 7'd1;
				apply_count(close_ticks, 1'b0);
				open_ticks = link_on ? 7'(rps_pkg::END_COUNT - int'(close_ticks)) : 7'd0;
			end
		end
		res.relays          = relay_bits;
		res.sequence_status = done_state;
		res.last_channel_on = top_on;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_result(input rps_pkg::out_item_t got);
		rps_pkg::out_item_t want;
		if (relay_results_due.size() == 0) begin
			report_mismatch($sformatf("result %h with nothing expected", got));
			return;
		end
		want = relay_results_due.pop_front();
		if (got.relays !== want.relays || got.sequence_status !== want.sequence_status ||
				got.last_channel_on !== want.last_channel_on)
			report_mismatch($sformatf("relays %h/%h status %0d/%0d last_on %b/%b (got/expected)",
				got.relays, want.relays, got.sequence_status, want.sequence_status,
				got.last_channel_on, want.last_channel_on));
	endtask

	// Receiver: check each accepted item, then stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result(out_data);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_tick(input logic down, input logic changed);
		rps_pkg::in_item_t tick;
		tick.key_down    = down;
		tick.key_changed = changed;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		relay_results_due.push_back(next_relay_result(tick));
		in_valid <= 1'b1;
		in_data  <= tick;
		do @(posedge clk); while (!in_ready);
	endtask

	// Leaves psel high so that writes can follow back to back.
	task automatic write_register(input rps_pkg::reg_idx_t idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= rps_pkg::ADDR_W'(int'(idx) * 8);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		unique case (idx)
			rps_pkg::REG_OPEN_DELAYS:    open_delay_bytes  = value;
			rps_pkg::REG_CLOSE_DELAYS:   close_delay_bytes = value;
			rps_pkg::REG_CHANNEL_ENABLE: enabled_mask      = value[7:0];
			rps_pkg::REG_LINK_MODE:      link_on           = value[0];
			default: ;
		endcase
	endtask

	task automatic configure(input logic [63:0] opens, input logic [63:0] closes,
			input logic [7:0] mask, input logic link);
		write_register(rps_pkg::REG_OPEN_DELAYS, opens);
		write_register(rps_pkg::REG_CLOSE_DELAYS, closes);
		write_register(rps_pkg::REG_CHANNEL_ENABLE, {56'd0, mask});
		write_register(rps_pkg::REG_LINK_MODE, {63'd0, link});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop valid and wait for every outstanding item to come back.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (relay_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	function automatic logic [63:0] random_delays();
		logic [63:0] bytes;
		int          r;
		for (int ch = 0; ch < 8; ch++) begin
			r = $urandom_range(99);
			if (r < 70)
				bytes[8*ch +: 8] = 8'($urandom_range(1, 8));
			else if (r < 85)
				bytes[8*ch +: 8] = 8'd0;
			else if (r < 93)
				bytes[8*ch +: 8] = 8'($urandom_range(9, 12));
			else
				bytes[8*ch +: 8] = 8'($urandom_range(13, 255));
		end
		return bytes;
	endfunction

	task automatic test_input_extremes();
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
	endtask

	task automatic test_link_change_ignored();
		settle_block();
		configure('0, '0, 8'hFF, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b1);
		send_tick(1'b0, 1'b1);
		send_tick(1'b1, 1'b0);
	endtask

	// Zero, too-long and maximum delays, a disabled channel, and the top channel flag.
	task automatic test_delay_edges();
		settle_block();
		configure(64'h01_02_01_08_FF_09_00_01, 64'h08_01_01_01_01_01_01_01, 8'hDF, 1'b0);
		send_tick(1'b1, 1'b1);
		repeat (9) send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		repeat (9) send_tick(1'b0, 1'b0);
	endtask

	// Mostly whole sequences with a change flag up front, plus stray ticks.
	task automatic run_sequences(input int budget);
		int   sent;
		int   len;
		logic down;
		sent = 0;
		while (sent < budget) begin
			down = 1'($urandom_range(1));
			len  = ($urandom_range(99) < 60) ? $urandom_range(78, 92) : $urandom_range(1, 30);
			for (int i = 0; i < len && sent < budget; i++) begin
				if ($urandom_range(99) < 6)
					send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
				else
					send_tick(down, i == 0 && $urandom_range(99) < 90);
				sent++;
			end
		end
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int s = 0; s < 4; s++) begin
			settle_block();
			unique case (s)
				0: configure('1, '0, 8'h00, 1'b1);
				1: configure(random_delays(), random_delays(), 8'hFF, 1'b1);
				default: configure(random_delays(), random_delays(),
					($urandom_range(99) < 20) ? 8'hFF : 8'($urandom_range(255)), 1'b0);
			endcase
			run_sequences(100);
		end
	endtask

	initial begin
		#LIMIT_NS;
		$display("status: fail");
		$finish;
	end

	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		in_data           = '0;
		out_ready         = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		mismatch_count    = 0;
		send_idle_pct     = 14;
		recv_idle_pct     = 46;
		open_delay_bytes  = '0;
		close_delay_bytes = '0;
		enabled_mask      = 8'hFF;
		link_on           = 1'b0;
		open_ticks        = '0;
		close_ticks       = '0;
		done_state        = rps_pkg::ST_RUN;
		relay_bits        = '0;
		top_on            = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_input_extremes();
		test_link_change_ignored();
		test_delay_edges();
		test_random_phase(14, 46);
		test_random_phase(46, 14);
		test_random_phase(0, 0);
		settle_block();
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
